FILE: hw/rtl/mcesa_pkg.sv
// Shared types, codes and constants of the multi-channel EMA spread alarm.
`timescale 1ns / 1ps

package mcesa_pkg;

	// Default number of sources held in the average store.
	localparam int MAX_SOURCES_DEF = 16;

	// Configuration port.
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 16;

	localparam logic [CFG_IW-1:0] CFG_GAIN       = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_MIN_SAMP   = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_THRESHOLD  = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_RELEASE    = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_ACTIVE     = 3'd4;

	localparam logic [15:0] RST_GAIN      = 16'd6554;
	localparam logic [15:0] RST_MIN_SAMP  = 16'd1;
	localparam logic [15:0] RST_THRESHOLD = 16'd19661;
	localparam logic [15:0] RST_RELEASE   = 16'd52429;
	localparam logic [4:0]  RST_ACTIVE    = 5'd0;

	// Store entry: sample count in the upper half, average in the lower half.
	localparam int ENTRY_W = 32;

	// Stream payload widths.
	localparam int IN_TDATA_W    = 24;
	localparam int OUT_TDATA_W   = 112;
	localparam int OUT_ALARM_BIT = 16;

	// Result status codes.
	localparam logic [1:0] ST_NONE    = 2'd0;
	localparam logic [1:0] ST_ONSET   = 2'd1;
	localparam logic [1:0] ST_RECOVER = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	// Kind of transaction being finished by the controller.
	localparam logic [1:0] KIND_REC = 2'd0;
	localparam logic [1:0] KIND_CLR = 2'd1;
	localparam logic [1:0] KIND_INV = 2'd2;

	typedef struct packed {
		logic       cap;
		logic       rd;
		logic       mul;
		logic       wr;
		logic       scan;
		logic       fin;
		logic       load;
		logic [1:0] kind;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_clear;
		logic in_src_ok;
		logic scan_done;
		logic out_free;
	} ctrl_stat_t;

endpackage

FILE: hw/rtl/mcesa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module mcesa_ram #(
	parameter int WIDTH = mcesa_pkg::ENTRY_W,
	parameter int DEPTH = mcesa_pkg::MAX_SOURCES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/mcesa_ctrl.sv
// Controller state machine sequencing one transaction through the datapath.
`timescale 1ns / 1ps

module mcesa_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_tvalid,
	output logic                   in_tready,
	input  mcesa_pkg::ctrl_stat_t  stat,
	output mcesa_pkg::ctrl_cmd_t   cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_WR   = 3'd3;
	localparam logic [2:0] S_SCAN = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;
	localparam logic [2:0] S_LOAD = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] kind_q;
	logic [1:0] kind_d;

	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		in_tready = 1'b0;
		cmd       = '0;
		cmd.kind  = kind_q;
		unique case (state_q)
			S_IDLE: begin
				in_tready = 1'b1;
				if (in_tvalid) begin
					cmd.cap = 1'b1;
					if (stat.in_clear) begin
						kind_d  = mcesa_pkg::KIND_CLR;
						state_d = S_LOAD;
					end else if (!stat.in_src_ok) begin
						kind_d  = mcesa_pkg::KIND_INV;
						state_d = S_LOAD;
					end else begin
						kind_d  = mcesa_pkg::KIND_REC;
						state_d = S_RD;
					end
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_WR;
			end
			S_WR: begin
				cmd.wr  = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				if (stat.out_free) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= mcesa_pkg::KIND_REC;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

endmodule

FILE: hw/rtl/mcesa_dp.sv
// Datapath: configuration, average store, EMA update, spread scan, alarm and result register.
`timescale 1ns / 1ps

module mcesa_dp #(
	parameter int MAX_SOURCES = mcesa_pkg::MAX_SOURCES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mcesa_pkg::CFG_IW-1:0]       cfg_index,
	input  logic [mcesa_pkg::CFG_DW-1:0]       cfg_data,
	input  logic                               in_tuser,
	input  logic [mcesa_pkg::IN_TDATA_W-1:0]   in_tdata,
	input  mcesa_pkg::ctrl_cmd_t               cmd,
	output mcesa_pkg::ctrl_stat_t              stat,
	input  logic                               out_tready,
	output logic                               out_tvalid,
	output logic [1:0]                         out_tuser,
	output logic [mcesa_pkg::OUT_TDATA_W-1:0]  out_tdata
);

	localparam int AW = $clog2(MAX_SOURCES);
	localparam int NW = $clog2(MAX_SOURCES + 1);
	localparam int LW = (NW > 5) ? NW : 5;

	// Configuration registers.
	logic [15:0] gain_q;
	logic [15:0] min_samp_q;
	logic [15:0] thr_q;
	logic [15:0] rel_frac_q;
	logic [4:0]  active_q;
	logic [31:0] rel_prod;
	logic [15:0] rel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q     <= mcesa_pkg::RST_GAIN;
			min_samp_q <= mcesa_pkg::RST_MIN_SAMP;
			thr_q      <= mcesa_pkg::RST_THRESHOLD;
			rel_frac_q <= mcesa_pkg::RST_RELEASE;
			active_q   <= mcesa_pkg::RST_ACTIVE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mcesa_pkg::CFG_GAIN:      gain_q     <= cfg_data;
				mcesa_pkg::CFG_MIN_SAMP:  min_samp_q <= cfg_data;
				mcesa_pkg::CFG_THRESHOLD: thr_q      <= cfg_data;
				mcesa_pkg::CFG_RELEASE:   rel_frac_q <= cfg_data;
				mcesa_pkg::CFG_ACTIVE:    active_q   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Release level, refreshed every cycle from the configuration.
	assign rel_prod = 32'(thr_q) * 32'(rel_frac_q);

	always_ff @(posedge clk) begin
		rel_q <= rel_prod[31:16];
	end

	// Number of sources taking part, capped at the store depth.
	logic [LW-1:0] act_ext;
	logic [LW-1:0] max_c;
	logic [LW-1:0] n_lim;

	assign act_ext = LW'(active_q);
	assign max_c   = LW'(MAX_SOURCES);
	assign n_lim   = (act_ext > max_c) ? max_c : act_ext;

	// Captured transaction.
	logic [AW-1:0] src_q;
	logic [15:0]   x_q;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			src_q <= AW'(in_tdata[3:0]);
			x_q   <= in_tdata[19:4];
		end
	end

	// Store.
	logic                 ram_we;
	logic [31:0]          ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [31:0]          ram_rdata;
	logic [LW-1:0]        k_q;
	logic [MAX_SOURCES-1:0] valid_q;

	assign ram_raddr = cmd.rd ? src_q : k_q[AW-1:0];

	mcesa_ram #(
		.WIDTH (mcesa_pkg::ENTRY_W),
		.DEPTH (MAX_SOURCES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (src_q),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// EMA update.
	logic signed [15:0] ema_old;
	logic [15:0]        cnt_old;
	logic signed [16:0] diff;
	logic signed [33:0] prod;
	logic signed [33:0] prod_q;
	logic signed [15:0] ema_q;
	logic [15:0]        cnt_q;
	logic signed [17:0] sum;
	logic signed [15:0] new_avg;
	logic [15:0]        new_cnt;
	logic signed [15:0] upd_q;

	assign ema_old = valid_q[src_q] ? $signed(ram_rdata[15:0]) : 16'sd0;
	assign cnt_old = valid_q[src_q] ? ram_rdata[31:16] : 16'd0;
	assign diff    = $signed({x_q[15], x_q}) - $signed({ema_old[15], ema_old});
	assign prod    = $signed({1'b0, gain_q}) * diff;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= prod;
			ema_q  <= ema_old;
			cnt_q  <= cnt_old;
		end
		if (cmd.wr) begin
			upd_q <= new_avg;
		end
	end

	assign sum = $signed({{2{ema_q[15]}}, ema_q}) + $signed(prod_q[33:16]);

	always_comb begin
		if (sum > 18'sd32767) begin
			new_avg = 16'sh7FFF;
		end else if (sum < -18'sd32768) begin
			new_avg = 16'sh8000;
		end else begin
			new_avg = sum[15:0];
		end
	end

	assign new_cnt   = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;
	assign ram_we    = cmd.wr;
	assign ram_wdata = {new_cnt, new_avg};

	// Spread scan: running maximum and minimum with the first index of each.
	logic               pend_s1;
	logic [AW-1:0]      idx_s1;
	logic               seen_q;
	logic signed [15:0] max_q;
	logic signed [15:0] min_q;
	logic [AW-1:0]      fmax_q;
	logic [AW-1:0]      fmin_q;
	logic signed [15:0] sc_val;
	logic [15:0]        sc_cnt;
	logic               sc_qual;
	logic               k_more;

	assign sc_val  = valid_q[idx_s1] ? $signed(ram_rdata[15:0]) : 16'sd0;
	assign sc_cnt  = valid_q[idx_s1] ? ram_rdata[31:16] : 16'd0;
	assign sc_qual = pend_s1 && (sc_cnt >= min_samp_q);
	assign k_more  = k_q < n_lim;

	always_ff @(posedge clk) begin
		if (cmd.scan && k_more) begin
			idx_s1 <= k_q[AW-1:0];
		end
		if (sc_qual) begin
			if (!seen_q || (sc_val > max_q)) begin
				max_q  <= sc_val;
				fmax_q <= idx_s1;
			end
			if (!seen_q || (sc_val < min_q)) begin
				min_q  <= sc_val;
				fmin_q <= idx_s1;
			end
		end
	end

	// Scan result.
	logic signed [16:0] span;
	logic [15:0]        spread_new;
	logic               pair_hit;
	logic [AW-1:0]      pa_q;
	logic [AW-1:0]      pb_q;

	assign span       = $signed({max_q[15], max_q}) - $signed({min_q[15], min_q});
	assign spread_new = seen_q ? span[15:0] : 16'd0;
	assign pair_hit   = seen_q && (max_q != min_q);

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			if (!pair_hit) begin
				pa_q <= '0;
				pb_q <= '0;
			end else if (fmax_q < fmin_q) begin
				pa_q <= fmax_q;
				pb_q <= fmin_q;
			end else begin
				pa_q <= fmin_q;
				pb_q <= fmax_q;
			end
		end
	end

	// Alarm and result assembly.
	logic        alarm_q;
	logic [15:0] cur_spread_q;
	logic [31:0] onset_q;
	logic [31:0] recov_q;
	logic        onset_hit;
	logic        recov_hit;
	logic [1:0]  res_status;
	logic [15:0] res_spread;
	logic        res_alarm;
	logic [3:0]  res_pa;
	logic [3:0]  res_pb;
	logic [15:0] res_upd;
	logic [31:0] res_onset;
	logic [31:0] res_recov;

	assign onset_hit = !alarm_q && (cur_spread_q > thr_q);
	assign recov_hit = alarm_q && (cur_spread_q < rel_q);

	always_comb begin
		res_status = mcesa_pkg::ST_NONE;
		res_spread = cur_spread_q;
		res_alarm  = alarm_q;
		res_pa     = 4'd0;
		res_pb     = 4'd0;
		res_upd    = 16'd0;
		res_onset  = onset_q;
		res_recov  = recov_q;
		unique case (cmd.kind)
			mcesa_pkg::KIND_REC: begin
				res_pa  = 4'(pa_q);
				res_pb  = 4'(pb_q);
				res_upd = upd_q;
				if (onset_hit) begin
					res_status = mcesa_pkg::ST_ONSET;
					res_alarm  = 1'b1;
					res_onset  = onset_q + 32'd1;
				end else if (recov_hit) begin
					res_status = mcesa_pkg::ST_RECOVER;
					res_alarm  = 1'b0;
					res_recov  = recov_q + 32'd1;
				end
			end
			mcesa_pkg::KIND_CLR: begin
				res_spread = 16'd0;
				res_alarm  = 1'b0;
			end
			mcesa_pkg::KIND_INV: begin
				res_status = mcesa_pkg::ST_INVALID;
			end
			default: ;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			cur_spread_q <= 16'd0;
			alarm_q      <= 1'b0;
			onset_q      <= 32'd0;
			recov_q      <= 32'd0;
			out_tvalid   <= 1'b0;
			k_q          <= '0;
			pend_s1      <= 1'b0;
			seen_q       <= 1'b0;
		end else begin
			if (cmd.load) begin
				out_tvalid <= 1'b1;
			end else if (out_tready) begin
				out_tvalid <= 1'b0;
			end
			if (cmd.wr) begin
				valid_q[src_q] <= 1'b1;
				k_q            <= '0;
				pend_s1        <= 1'b0;
				seen_q         <= 1'b0;
			end
			if (cmd.scan) begin
				pend_s1 <= k_more;
				if (k_more) begin
					k_q <= k_q + LW'(1);
				end
			end
			if (sc_qual) begin
				seen_q <= 1'b1;
			end
			if (cmd.fin) begin
				cur_spread_q <= spread_new;
			end
			if (cmd.load) begin
				cur_spread_q <= res_spread;
				alarm_q      <= res_alarm;
				onset_q      <= res_onset;
				recov_q      <= res_recov;
				if (cmd.kind == mcesa_pkg::KIND_CLR) begin
					valid_q <= '0;
				end
			end
		end
	end

	// Result register payload.
	logic [1:0]  o_status_q;
	logic [15:0] o_spread_q;
	logic        o_alarm_q;
	logic [3:0]  o_pa_q;
	logic [3:0]  o_pb_q;
	logic [31:0] o_onset_q;
	logic [31:0] o_recov_q;
	logic [15:0] o_upd_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			o_status_q <= res_status;
			o_spread_q <= res_spread;
			o_alarm_q  <= res_alarm;
			o_pa_q     <= res_pa;
			o_pb_q     <= res_pb;
			o_onset_q  <= res_onset;
			o_recov_q  <= res_recov;
			o_upd_q    <= res_upd;
		end
	end

	assign out_tuser = o_status_q;
	assign out_tdata = {7'd0, o_upd_q, o_recov_q, o_onset_q, o_pb_q, o_pa_q,
		o_alarm_q, o_spread_q};

	assign stat.in_clear  = in_tuser;
	assign stat.in_src_ok = LW'(in_tdata[3:0]) < n_lim;
	assign stat.scan_done = !k_more;
	assign stat.out_free  = !out_tvalid || out_tready;

endmodule

FILE: hw/rtl/multi_channel_ema_spread_alarm_top.sv
// Top level of the multi-channel EMA spread alarm: controller, datapath and ports.
`timescale 1ns / 1ps

// A record transaction reads and updates its source's entry, then scans the N active
// sources (N capped at MAX_SOURCES) before its result is loaded; clear and rejected
// transactions go straight to the load. The spread scan reads one store entry per cycle
// through the single read port. A new transaction is accepted only once the last is loaded;
// a result still waiting in the output register holds back only the next load.
// Reset (arst_n low, asynchronous) sets config and control registers to their defaults and
// empties the store at once through per-entry valid bits, so no clearing pass is needed.

module multi_channel_ema_spread_alarm_top #(
	parameter int MAX_SOURCES = mcesa_pkg::MAX_SOURCES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,

	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [mcesa_pkg::CFG_IW-1:0]      cfg_index,
	input  logic [mcesa_pkg::CFG_DW-1:0]      cfg_data,

	// Input stream.
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// tuser: cmd (bit 0).
	input  logic                              s_axis_tuser,
	// tdata: source_index [3:0], sentiment [19:4], zero padding [23:20].
	input  logic [mcesa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,

	// Result stream.
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// tuser: status [1:0].
	output logic [1:0]                        m_axis_tuser,
	// tdata: spread [15:0], alarm_active [16], pair_first [20:17], pair_second [24:21],
	// onset_count [56:25], recovery_count [88:57], updated_average [104:89],
	// zero padding [111:105].
	output logic [mcesa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	// The controller walks each record transaction through read, multiply, write-back, scan,
	// finish and load; the datapath holds the data registers and the store. The two are
	// joined only by the command and status structs below.
	mcesa_pkg::ctrl_cmd_t  cmd;
	mcesa_pkg::ctrl_stat_t stat;

	mcesa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tvalid (s_axis_tvalid),
		.in_tready (s_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The result register in the datapath parts the two sides: a new transaction is
	// accepted while the previous result still waits, and only the final load waits
	// for the register to free up.
	mcesa_dp #(
		.MAX_SOURCES (MAX_SOURCES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_tuser   (s_axis_tuser),
		.in_tdata   (s_axis_tdata),
		.cmd        (cmd),
		.stat       (stat),
		.out_tready (m_axis_tready),
		.out_tvalid (m_axis_tvalid),
		.out_tuser  (m_axis_tuser),
		.out_tdata  (m_axis_tdata)
	);

endmodule

FILE: hw/rtl/mcesa_checker.sv
// Port-level assertions for the spread alarm top level, with the bind that attaches them.
`timescale 1ns / 1ps

module mcesa_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [1:0]                        m_axis_tuser,
	input logic [mcesa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// An onset always reports the alarm as active.
	a_onset_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == mcesa_pkg::ST_ONSET) |->
		m_axis_tdata[mcesa_pkg::OUT_ALARM_BIT])
		else $error("onset reported with alarm inactive");

	// A recovery always reports the alarm as released.
	a_recover_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == mcesa_pkg::ST_RECOVER) |->
		!m_axis_tdata[mcesa_pkg::OUT_ALARM_BIT])
		else $error("recovery reported with alarm active");

	// One transaction at a time: acceptance closes the input for the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted on consecutive cycles");

endmodule

bind multi_channel_ema_spread_alarm_top mcesa_checker u_mcesa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tdata  (m_axis_tdata)
);
